FILE: rtl/tst_pkg.sv
// shared types, constants and the precast saturation for the stability tracker
`default_nettype none

package tst_pkg;

  // window of past samples held in the cell chain
  localparam int unsigned WINDOW_DEPTH = 60;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned COEF_W = 20;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // counter values that trigger events
  localparam logic [COUNT_W-1:0] START_TIMEOUT = 16'd60;
  localparam logic [COUNT_W-1:0] PRECAST_AT = 16'd51;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // taps read before the shift; tap k holds the sample k+1 items back
  // at the precast word the new sample is window entry 50, tap 9 entry 40,
  // tap 19 entry 30 and tap 29 entry 20
  localparam int unsigned TAP_W40 = 9;
  localparam int unsigned TAP_W30 = 19;
  localparam int unsigned TAP_W20 = 29;
  // oldest entry still in the window after the new sample is written
  localparam int unsigned TAP_OLDEST = WINDOW_DEPTH - 2;

  // precast arithmetic widths
  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned PROD_W = COEF_W + DIFF_W;
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned FRAC_W = 12;

  // register reset values
  localparam logic [15:0] RST_START_THRESHOLD = 16'd3400;
  localparam logic [15:0] RST_STABLE_DELTA = 16'd3;
  localparam logic [15:0] RST_STABLE_START_COUNT = 16'd300;
  localparam logic [15:0] RST_MAX_COUNT = 16'd1800;
  localparam logic [15:0] RST_AFTER_STABLE_COUNT = 16'd180;
  localparam logic signed [COEF_W-1:0] RST_COEF_FIRST = 20'sd38726;
  localparam logic signed [COEF_W-1:0] RST_COEF_SECOND = -20'sd96750;
  localparam logic signed [COEF_W-1:0] RST_COEF_THIRD = 20'sd94251;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_THRESHOLD    = 3'd0,
    REG_STABLE_DELTA       = 3'd1,
    REG_STABLE_START_COUNT = 3'd2,
    REG_MAX_COUNT          = 3'd3,
    REG_AFTER_STABLE_COUNT = 3'd4,
    REG_COEF_FIRST         = 3'd5,
    REG_COEF_SECOND        = 3'd6,
    REG_COEF_THIRD         = 3'd7
  } reg_idx_e;

  // event codes of a result word
  typedef enum logic [1:0] {
    EV_POWER_OFF = 2'd0,
    EV_PRECAST   = 2'd1,
    EV_STABLE    = 2'd2
  } event_e;

  // thresholds and counts used by the sequencing logic
  typedef struct packed {
    logic [15:0] start_threshold;
    logic [15:0] stable_delta;
    logic [15:0] stable_start_count;
    logic [15:0] max_count;
    logic [15:0] after_stable_count;
  } cfg_t;

  // per-word decision from the sequencing logic
  typedef struct packed {
    logic   shift;
    logic   valid;
    event_e ev;
    logic   pre;
  } step_t;

  // truncate the Q12 sum toward zero and clamp to 0..65535
  function automatic logic [SAMPLE_W-1:0] precast_sat(input logic signed [SUM_W-1:0] t);
    logic [SAMPLE_W-1:0] res;
    res = '0;
    if (t[SUM_W-1] || (t == '0)) begin
      res = '0;
    end else if (|t[SUM_W-2:FRAC_W+SAMPLE_W]) begin
      res = '1;
    end else begin
      res = t[FRAC_W+SAMPLE_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tst_in_if.sv
// input channel carrying one temperature sample word
`default_nettype none

interface tst_in_if;
  logic                            valid;
  logic                            ready;
  logic [tst_pkg::SAMPLE_W-1:0]    sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/tst_out_if.sv
// output channel carrying one event word
`default_nettype none

interface tst_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      event_res;
  logic [tst_pkg::SAMPLE_W-1:0]    predicted_temp;

  modport source (output valid, output event_res, output predicted_temp, input ready);
  modport sink (input valid, input event_res, input predicted_temp, output ready);
endinterface

`default_nettype wire

FILE: rtl/tst_cell.sv
// one window cell: holds a sample and passes it on at every shift
`default_nettype none

module tst_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         shift_i,
  input  wire logic [tst_pkg::SAMPLE_W-1:0] d_i,
  output logic      [tst_pkg::SAMPLE_W-1:0] q_o
);

  logic [tst_pkg::SAMPLE_W-1:0] data_q;
  logic [tst_pkg::SAMPLE_W-1:0] data_d;

  // take the neighbor's sample on a shift
  always_comb begin
    data_d = shift_i ? d_i : data_q;
  end

  // window starts cleared to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign q_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/tst_ctrl.sv
// phase sequencing, sample and stability counters, event decision
`default_nettype none

module tst_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [tst_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic [tst_pkg::SAMPLE_W-1:0] oldest_i,
  input  wire tst_pkg::cfg_t                cfg_i,
  output tst_pkg::step_t                    step_o
);

  typedef enum logic [1:0] {
    WAIT_COOL  = 2'd0,
    WAIT_START = 2'd1,
    MEASURE    = 2'd2
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic                          stable_q, stable_d;
  logic [tst_pkg::COUNT_W-1:0]   count_q, count_d;
  logic [tst_pkg::COUNT_W-1:0]   scount_q, scount_d;
  logic [tst_pkg::COUNT_W-1:0]   count_inc;
  logic [tst_pkg::COUNT_W-1:0]   scount_inc;
  logic                          warm;
  logic [tst_pkg::SAMPLE_W:0]    rise;
  logic                          rise_ok;
  tst_pkg::step_t                step;

  // saturating increments and the rise over the window
  always_comb begin
    count_inc  = (count_q == tst_pkg::COUNT_MAX) ? count_q : count_q + 16'd1;
    scount_inc = (scount_q == tst_pkg::COUNT_MAX) ? scount_q : scount_q + 16'd1;
    warm       = (sample_i >= cfg_i.start_threshold);
    rise       = {1'b0, sample_i} - {1'b0, oldest_i};
    rise_ok    = !rise[tst_pkg::SAMPLE_W] && (rise[tst_pkg::SAMPLE_W-1:0] <= cfg_i.stable_delta);
  end

  // next state and event for the word on the input
  always_comb begin
    phase_d  = phase_q;
    stable_d = stable_q;
    count_d  = count_q;
    scount_d = scount_q;
    step     = '{shift: 1'b0, valid: 1'b0, ev: tst_pkg::EV_POWER_OFF, pre: 1'b0};
    if (accept_i) begin
      case (phase_q)
        WAIT_COOL: begin
          if (!warm) begin
            phase_d = WAIT_START;
          end
        end
        WAIT_START: begin
          if (warm) begin
            step.shift = 1'b1;
            count_d    = 16'd1;
            phase_d    = MEASURE;
          end else begin
            count_d = count_inc;
            if (count_inc == tst_pkg::START_TIMEOUT) begin
              step.valid = 1'b1;
            end
          end
        end
        MEASURE: begin
          step.shift = 1'b1;
          count_d    = count_inc;
          if (count_inc == tst_pkg::PRECAST_AT) begin
            step.valid = 1'b1;
            step.ev    = tst_pkg::EV_PRECAST;
            step.pre   = 1'b1;
          end else if (count_inc < cfg_i.stable_start_count) begin
            step.valid = 1'b0;
          end else if (count_inc > cfg_i.max_count) begin
            step.valid = 1'b1;
          end else if (!stable_q) begin
            if (rise_ok) begin
              stable_d   = 1'b1;
              scount_d   = 16'd1;
              step.valid = 1'b1;
              step.ev    = tst_pkg::EV_STABLE;
            end
          end else begin
            scount_d = scount_inc;
            if (scount_inc == cfg_i.after_stable_count) begin
              step.valid = 1'b1;
            end
          end
        end
        default: begin
          phase_d = WAIT_COOL;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= WAIT_COOL;
      stable_q <= 1'b0;
      count_q  <= '0;
      scount_q <= '0;
    end else begin
      phase_q  <= phase_d;
      stable_q <= stable_d;
      count_q  <= count_d;
      scount_q <= scount_d;
    end
  end

  assign step_o = step;

endmodule

`default_nettype wire

FILE: rtl/thermometer_stability_tracker.sv
// top level: config registers, window cell chain, precast pipeline, output register
// Usage:
//   Samples arrive on in_i (valid/ready); a word is taken at a clock edge with
//   valid and ready high. Event words leave on out_o with event_res and
//   predicted_temp; each sample gives zero or one event word.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   no word is in flight; 16-bit registers take the low data bits.
// Timing:
//   The edge that takes a sample registers the three coefficient products; a later
//   edge, once the output register is free, adds them, clamps and loads it. One
//   sample a cycle is taken back to back unless a stall drops in_i.ready; the window
//   is a chain of 60 cells that shifts on each sample that starts or is in MEASURE.
// Reset:
//   rst_ni clears phase, counters, window cells and both pipeline stages and
//   restores the register defaults; the block is ready in the cycle after.
// Stall:
//   while out_o.ready is low the result waits in the output register; samples
//   that give no word keep flowing, one more event word is still taken into
//   the product stage, after which in_i.ready drops.
`default_nettype none

module thermometer_stability_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  tst_in_if.sink                              in_i,
  tst_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [tst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tst_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SW = tst_pkg::SAMPLE_W;

  tst_pkg::cfg_t                          cfg_q;
  logic signed [tst_pkg::COEF_W-1:0]      coef1_q, coef2_q, coef3_q;
  logic                                   accept;
  tst_pkg::step_t                         step;
  logic [SW-1:0]                          tap [tst_pkg::WINDOW_DEPTH];

  logic signed [tst_pkg::DIFF_W-1:0]      diff1, diff2, diff3;
  logic                                   s1_valid_q;
  tst_pkg::event_e                        s1_ev_q;
  logic                                   s1_pre_q;
  logic signed [tst_pkg::PROD_W-1:0]      p1_q, p2_q, p3_q;
  logic [SW-1:0]                          w50_q;
  logic signed [tst_pkg::SUM_W-1:0]       total;
  logic                                   out_load;
  logic                                   out_valid_q;
  tst_pkg::event_e                        out_ev_q;
  logic [SW-1:0]                          out_temp_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_threshold    <= tst_pkg::RST_START_THRESHOLD;
      cfg_q.stable_delta       <= tst_pkg::RST_STABLE_DELTA;
      cfg_q.stable_start_count <= tst_pkg::RST_STABLE_START_COUNT;
      cfg_q.max_count          <= tst_pkg::RST_MAX_COUNT;
      cfg_q.after_stable_count <= tst_pkg::RST_AFTER_STABLE_COUNT;
      coef1_q                  <= tst_pkg::RST_COEF_FIRST;
      coef2_q                  <= tst_pkg::RST_COEF_SECOND;
      coef3_q                  <= tst_pkg::RST_COEF_THIRD;
    end else if (cfg_we_i) begin
      case (tst_pkg::reg_idx_e'(cfg_idx_i))
        tst_pkg::REG_START_THRESHOLD:    cfg_q.start_threshold    <= cfg_data_i[15:0];
        tst_pkg::REG_STABLE_DELTA:       cfg_q.stable_delta       <= cfg_data_i[15:0];
        tst_pkg::REG_STABLE_START_COUNT: cfg_q.stable_start_count <= cfg_data_i[15:0];
        tst_pkg::REG_MAX_COUNT:          cfg_q.max_count          <= cfg_data_i[15:0];
        tst_pkg::REG_AFTER_STABLE_COUNT: cfg_q.after_stable_count <= cfg_data_i[15:0];
        tst_pkg::REG_COEF_FIRST:         coef1_q <= $signed(cfg_data_i);
        tst_pkg::REG_COEF_SECOND:        coef2_q <= $signed(cfg_data_i);
        tst_pkg::REG_COEF_THIRD:         coef3_q <= $signed(cfg_data_i);
        default:                         coef1_q <= coef1_q;
      endcase
    end
  end

  // input handshake: the product stage frees up when it is empty or moving on
  assign out_load     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready   = !s1_valid_q || out_load;
  assign accept       = in_i.valid && in_i.ready;

  // sequencing logic
  tst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (in_i.sample),
    .oldest_i (tap[tst_pkg::TAP_OLDEST]),
    .cfg_i    (cfg_q),
    .step_o   (step)
  );

  // window: a chain of cells, newest sample enters at cell 0
  for (genvar k = 0; k < tst_pkg::WINDOW_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      tst_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (step.shift),
        .d_i     (in_i.sample),
        .q_o     (tap[k])
      );
    end else begin : g_body
      tst_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (step.shift),
        .d_i     (tap[k-1]),
        .q_o     (tap[k])
      );
    end
  end

  // differences between window entries 20, 30, 40 and 50
  always_comb begin
    diff1 = $signed({1'b0, tap[tst_pkg::TAP_W30]}) - $signed({1'b0, tap[tst_pkg::TAP_W20]});
    diff2 = $signed({1'b0, tap[tst_pkg::TAP_W40]}) - $signed({1'b0, tap[tst_pkg::TAP_W30]});
    diff3 = $signed({1'b0, in_i.sample}) - $signed({1'b0, tap[tst_pkg::TAP_W40]});
  end

  // product stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= step.valid;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  // product stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ev_q  <= step.ev;
      s1_pre_q <= step.pre;
      p1_q     <= coef1_q * diff1;
      p2_q     <= coef2_q * diff2;
      p3_q     <= coef3_q * diff3;
      w50_q    <= in_i.sample;
    end
  end

  // Q12 sum of the products and the newest sample
  always_comb begin
    total = tst_pkg::SUM_W'(p1_q) + tst_pkg::SUM_W'(p2_q) + tst_pkg::SUM_W'(p3_q)
          + $signed({{(tst_pkg::SUM_W - SW - tst_pkg::FRAC_W){1'b0}}, w50_q,
                     {tst_pkg::FRAC_W{1'b0}}});
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ev_q   <= s1_ev_q;
      out_temp_q <= s1_pre_q ? tst_pkg::precast_sat(total) : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.event_res      = out_ev_q;
  assign out_o.predicted_temp = out_temp_q;

endmodule

`default_nettype wire
